[hdl/ptw_pkg.sv]
// Package for the page table walker: widths, codes, item types and helpers.
package ptw_pkg;

   localparam int PHYS_ADDR_BITS = 52;           // implemented physical address bits
   localparam int ADDR_W         = 52;           // width of address fields in a result
   localparam int VA_W           = 48;
   localparam int DATA_W         = 64;
   localparam int PAGE_BITS      = 12;
   localparam int IDX_W          = 9;
   localparam int LEVEL_W        = 2;
   localparam int FAULT_LEVEL_W  = 3;

   localparam int ENTRY_PRESENT_BIT = 0;
   localparam int ENTRY_LARGE_BIT   = 7;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_RESP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } leaf_size_type;

   typedef enum logic [1:0] {
      CAUSE_NONE        = 2'd0,
      CAUSE_ZERO_FRAME  = 2'd1,
      CAUSE_READ_ERROR  = 2'd2,
      CAUSE_NOT_PRESENT = 2'd3
   } fault_cause_type;

   // table levels, numbered by the entry being read
   localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

   localparam logic [FAULT_LEVEL_W-1:0] FLVL_ROOT = 3'd0;

   typedef struct packed {
      command_type       command;
      logic [VA_W-1:0]   virt_addr;
      logic [DATA_W-1:0] mem_data;
      logic              mem_error;
   } req_type;

   typedef struct packed {
      kind_type                 result_kind;
      logic [ADDR_W-1:0]        read_addr;
      logic [ADDR_W-1:0]        phys_addr;
      leaf_size_type            leaf_size;
      fault_cause_type          fault_cause;
      logic [FAULT_LEVEL_W-1:0] fault_level;
   } rsp_type;

   typedef struct packed {
      logic              active;
      logic [LEVEL_W-1:0] level;
      logic [VA_W-1:0]   held_va;
   } walk_type;

   // 9-bit table index of a virtual address at a level
   function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         LVL_PML4: idx = va[47:39];
         LVL_PDPT: idx = va[38:30];
         LVL_PD:   idx = va[29:21];
         LVL_PT:   idx = va[20:12];
         default:  idx = '0;
      endcase
      return idx;
   endfunction

   // in-page offset mask of a leaf reached at a level
   function automatic logic [ADDR_W-1:0] offset_mask(input logic [LEVEL_W-1:0] lvl);
      logic [ADDR_W-1:0] mask;
      case (lvl)
         LVL_PDPT: mask = (ADDR_W'(1) << 30) - ADDR_W'(1);
         LVL_PD:   mask = (ADDR_W'(1) << 21) - ADDR_W'(1);
         default:  mask = (ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1);
      endcase
      return mask;
   endfunction

endpackage

[hdl/ptw_step.sv]
// Walk step: decodes one item against the walk state, gives next state and result.
module ptw_step (
   input  ptw_pkg::walk_type                                      walk,
   input  logic [ptw_pkg::PHYS_ADDR_BITS-1:ptw_pkg::PAGE_BITS]    root_frame,
   input  ptw_pkg::req_type                                       req,
   output ptw_pkg::walk_type                                      walk_next,
   output logic                                                   rsp_valid,
   output ptw_pkg::rsp_type                                       rsp
);
   import ptw_pkg::*;

   logic [PHYS_ADDR_BITS-1:PAGE_BITS] data_frame;
   logic [ADDR_W-1:0]                 frame_addr;
   logic [ADDR_W-1:0]                 ofs;
   logic [LEVEL_W-1:0]                next_level;
   logic [FAULT_LEVEL_W-1:0]          entry_level;
   logic                              is_leaf;

   assign data_frame  = req.mem_data[PHYS_ADDR_BITS-1:PAGE_BITS];
   assign frame_addr  = ADDR_W'({data_frame, PAGE_BITS'(0)});
   assign ofs         = offset_mask(walk.level);
   assign next_level  = walk.level + LEVEL_W'(1);
   assign entry_level = FAULT_LEVEL_W'(walk.level) + FAULT_LEVEL_W'(1);
   // PML4 large bit is ignored; a PT entry is always a leaf
   assign is_leaf = (walk.level == LVL_PT) ||
                    ((walk.level inside {LVL_PDPT, LVL_PD}) &&
                     req.mem_data[ENTRY_LARGE_BIT]);

   always_comb begin
      walk_next = walk;
      rsp_valid = 1'b0;
      rsp       = '{result_kind: KIND_READ, read_addr: '0, phys_addr: '0,
                    leaf_size: SIZE_4K, fault_cause: CAUSE_NONE, fault_level: '0};

      if (req.command == CMD_START) begin
         walk_next.held_va = req.virt_addr;
         rsp_valid         = 1'b1;
         if (root_frame == '0) begin
            walk_next.active = 1'b0;
            walk_next.level  = LVL_PML4;
            rsp.result_kind  = KIND_FAULT;
            rsp.fault_cause  = CAUSE_ZERO_FRAME;
            rsp.fault_level  = FLVL_ROOT;
         end else begin
            walk_next.active = 1'b1;
            walk_next.level  = LVL_PML4;
            rsp.read_addr    = ADDR_W'({root_frame, va_index(req.virt_addr, LVL_PML4),
                                        3'b000});
         end
      end else if (walk.active) begin
         rsp_valid = 1'b1;
         if (req.mem_error) begin
            walk_next.active = 1'b0;
            walk_next.level  = LVL_PML4;
            rsp.result_kind  = KIND_FAULT;
            rsp.fault_cause  = CAUSE_READ_ERROR;
            rsp.fault_level  = entry_level;
         end else if (!req.mem_data[ENTRY_PRESENT_BIT]) begin
            walk_next.active = 1'b0;
            walk_next.level  = LVL_PML4;
            rsp.result_kind  = KIND_FAULT;
            rsp.fault_cause  = CAUSE_NOT_PRESENT;
            rsp.fault_level  = entry_level;
         end else if (is_leaf) begin
            walk_next.active = 1'b0;
            walk_next.level  = LVL_PML4;
            rsp.result_kind  = KIND_DONE;
            rsp.phys_addr    = (frame_addr & ~ofs) | (ADDR_W'(walk.held_va) & ofs);
            case (walk.level)
               LVL_PDPT: rsp.leaf_size = SIZE_1G;
               LVL_PD:   rsp.leaf_size = SIZE_2M;
               default:  rsp.leaf_size = SIZE_4K;
            endcase
         end else if (data_frame == '0) begin
            walk_next.active = 1'b0;
            walk_next.level  = LVL_PML4;
            rsp.result_kind  = KIND_FAULT;
            rsp.fault_cause  = CAUSE_ZERO_FRAME;
            rsp.fault_level  = entry_level;
         end else begin
            walk_next.level = next_level;
            rsp.read_addr   = ADDR_W'({data_frame, va_index(walk.held_va, next_level),
                                       3'b000});
         end
      end
   end

endmodule

[hdl/page_table_walker.sv]
// Four-level x86-64 page table walker: top level with walk state and result buffering.
//
// Translates a 48-bit virtual address by reading one page table entry at a
// time. A start item latches the address and gives either a read request for
// the PML4 entry or, when the root frame is zero, a fault at level 0. Each
// response item from memory gives one result: the next read request, the
// translated address with its page size (1G, 2M or 4K), or a fault with its
// cause and level. A response while no walk is active is dropped without a
// result; a start during a walk abandons the walk. The root register is
// written through the csr port and should only be changed while idle.
// Rate: one item per cycle while req_stall is low. An item is decoded in the
// same cycle it is accepted; its result is registered before it shows on rsp. A
// two-entry output (result register plus skid register) lets req keep
// flowing while rsp is stalled; req_stall is raised only while the skid
// register is occupied, and comes straight from a flop.
module page_table_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptw_pkg::req_type      req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptw_pkg::rsp_type      rsp_item,
   input  logic                  csr_write_enable,
   input  logic [63:0]           csr_write_data
);
   import ptw_pkg::*;

   logic [PHYS_ADDR_BITS-1:PAGE_BITS] root_frame_ff, root_frame_in;
   walk_type                          walk_ff, walk_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_type                           rsp_item_ff, rsp_item_in;
   logic                              skid_valid_ff, skid_valid_in;
   rsp_type                           skid_item_ff, skid_item_in;

   walk_type step_walk;
   logic     step_valid;
   rsp_type  step_rsp;
   logic     req_accept;
   logic     out_free;
   logic     new_valid;

   ptw_step u_step (
      .walk       (walk_ff),
      .root_frame (root_frame_ff),
      .req        (req_item),
      .walk_next  (step_walk),
      .rsp_valid  (step_valid),
      .rsp        (step_rsp)
   );

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign new_valid  = req_accept && step_valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      root_frame_in = root_frame_ff;
      if (csr_write_enable) begin
         root_frame_in = csr_write_data[PHYS_ADDR_BITS-1:PAGE_BITS];
      end
      walk_in = req_accept ? step_walk : walk_ff;
   end

   // output register, backed by a skid slot while rsp is stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_valid;
            rsp_item_in  = step_rsp;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
         walk_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         root_frame_ff <= root_frame_in;
         walk_ff       <= walk_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   // skid slot only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid item present without result item");

   // idle walk always parks at the PML4 level
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      !walk_ff.active |-> (walk_ff.level == LVL_PML4))
      else $error("idle walk with nonzero level");

   // a done or fault result ends the walk
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (new_valid && (step_rsp.result_kind != KIND_READ)) |=> !walk_ff.active)
      else $error("walk still active after final result");

   // a response with no walk in progress yields nothing
   a_idle_resp_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_item.command == CMD_RESP) && !walk_ff.active) |-> !step_valid)
      else $error("result produced for response while idle");

   // an accepted start latches the address; the step also always gives it a result
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_item.command == CMD_START)) |=>
         (walk_ff.held_va == $past(req_item.virt_addr)))
      else $error("start item did not latch virtual address");

endmodule
